// ----- sv/alias_table_builder_macros.svh -----
// Assertion macros for the alias table row builder.
// Used by the top level only; no other dependencies.
`ifndef ALIAS_TABLE_BUILDER_MACROS_SVH
`define ALIAS_TABLE_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
`define ATB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ATB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ATB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/atb_pkg.sv -----
// Shared constants, register codes and controller/datapath structs
// for the alias table row builder. No dependencies.
package atb_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int MAX_COLUMNS_DEF = 32;

    localparam int PDF_W     = FRAC_BITS + 1;   // input probability
    localparam int WORK_W    = FRAC_BITS + 3;   // signed working value
    localparam int PROB_W    = FRAC_BITS + 3;   // scaled non-alias probability
    localparam int CNT_W     = 7;               // column count
    localparam int COL_W     = 6;               // column index fields
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COLS_RST  = CNT_W'(32);
    localparam logic [PDF_W-1:0] SHARE_RST = PDF_W'(541201);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_COUNT = 1'b0,
        CFG_EQUAL_SHARE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic load;       // write the transfer into the next slot
        logic search;     // capture donor and recipient
        logic update;     // apply one pass
        logic step_clr;
        logic step_inc;
        logic rd;         // read table entry at step
        logic out_load;   // fill output register
        logic row_clr;    // end of row: clear marks and load count
    } t_cmd;

    typedef struct packed {
        logic load_last;  // current load completes the row
        logic step_last;  // step is the last column in use
        logic out_free;   // output register can take a result
    } t_status;

endpackage

// ----- sv/atb_ctrl.sv -----
// Controller for the alias table row builder: load, pass and emit sequencing.
// Depends on atb_pkg.
module atb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  atb_pkg::t_status  i_status,
    output atb_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);
    import atb_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD    = 5'b00001,
        S_SEARCH  = 5'b00010,
        S_UPDATE  = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_WR = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.load_last) begin
                        o_cmd.step_clr = 1'b1;
                        n_state        = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_status.step_last) begin
                    o_cmd.step_clr = 1'b1;
                    n_state        = S_EMIT_RD;
                end else begin
                    o_cmd.step_inc = 1'b1;
                    n_state        = S_SEARCH;
                end
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                // hold the read result until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.step_last) begin
                        o_cmd.row_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        o_cmd.step_inc = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

// ----- sv/atb_dp.sv -----
// Datapath for the alias table row builder: config registers, working values,
// donor/recipient search, pass arithmetic, table memory and output register.
// Depends on atb_pkg.
module atb_dp #(
    parameter int MAX_COLUMNS = atb_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [atb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [atb_pkg::PDF_W-1:0]        i_cfg_data,
    input  logic [atb_pkg::PDF_W-1:0]        i_pdf_value,
    input  atb_pkg::t_cmd                    i_cmd,
    output atb_pkg::t_status                 o_status,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [atb_pkg::COL_W-1:0]        o_column_index,
    output logic [atb_pkg::COL_W-1:0]        o_alias_index,
    output logic [atb_pkg::PROB_W-1:0]       o_nonalias_prob,
    output logic                             o_assigned,
    output logic                             o_last_of_row
);
    import atb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_COLUMNS);
    localparam int DIFF_W = WORK_W + 2;
    localparam int PROD_W = CNT_W + WORK_W + 1;
    localparam int ENT_W  = IDX_W + PROB_W;

    localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_COLUMNS);
    localparam logic [CNT_W-1:0] N_MIN = CNT_W'(2);

    localparam logic signed [WORK_W-1:0] W_ZERO = '0;
    localparam logic signed [DIFF_W-1:0] D_MAX = {3'b000, {(WORK_W-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] D_MIN = {3'b111, {(WORK_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] P_MAX =
        $signed({{(PROD_W-PROB_W){1'b0}}, {PROB_W{1'b1}}});

    // configuration
    logic [CNT_W-1:0] r_cols;
    logic [PDF_W-1:0] r_share;
    logic [CNT_W-1:0] n_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COLS_RST;
            r_share <= SHARE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMN_COUNT: r_cols  <= i_cfg_data[CNT_W-1:0];
                CFG_EQUAL_SHARE:  r_share <= i_cfg_data;
                default:          r_cols  <= r_cols;
            endcase
        end
    end

    always_comb begin
        if (r_cols < N_MIN) begin
            n_use = N_MIN;
        end else if (r_cols > N_MAX) begin
            n_use = N_MAX;
        end else begin
            n_use = r_cols;
        end
    end

    // load and step counters
    logic [CNT_W-1:0] r_load_cnt;
    logic [CNT_W-1:0] r_step;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] slot_ext;

    always_comb begin
        if (r_load_cnt >= N_MAX) begin
            slot = IDX_W'(MAX_COLUMNS - 1);
        end else begin
            slot = r_load_cnt[IDX_W-1:0];
        end
        slot_ext = CNT_W'(slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_step     <= '0;
        end else begin
            if (i_cmd.row_clr || (i_cmd.load && o_status.load_last)) begin
                r_load_cnt <= '0;
            end else if (i_cmd.load) begin
                r_load_cnt <= slot_ext + CNT_W'(1);
            end
            if (i_cmd.step_clr || i_cmd.row_clr) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + CNT_W'(1);
            end
        end
    end

    // working values
    logic signed [WORK_W-1:0] r_work [MAX_COLUMNS];
    logic signed [WORK_W-1:0] share_s;
    logic [MAX_COLUMNS-1:0]   donor_hit;
    logic [MAX_COLUMNS-1:0]   recip_hit;
    logic [IDX_W-1:0]         donor_sel;
    logic [IDX_W-1:0]         recip_sel;
    logic [IDX_W-1:0]         r_d;
    logic [IDX_W-1:0]         r_r;

    assign share_s = $signed(WORK_W'(r_share));

    always_comb begin
        for (int j = 0; j < MAX_COLUMNS; j++) begin
            donor_hit[j] = (CNT_W'(j) < n_use) && (r_work[j] >= share_s);
            recip_hit[j] = (CNT_W'(j) < n_use) && (r_work[j] > W_ZERO)
                           && (r_work[j] < share_s);
        end
        donor_sel = '0;
        recip_sel = '0;
        // walk down so the lowest set column wins
        for (int j = MAX_COLUMNS - 1; j >= 0; j--) begin
            if (donor_hit[j]) donor_sel = IDX_W'(j);
            if (recip_hit[j]) recip_sel = IDX_W'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_d <= donor_sel;
            r_r <= recip_sel;
        end
    end

    // pass arithmetic
    logic signed [WORK_W-1:0] wd;
    logic signed [WORK_W-1:0] wr;
    logic signed [WORK_W:0]   shortfall;
    logic signed [DIFF_W-1:0] diff;
    logic signed [WORK_W-1:0] donor_new;
    logic signed [PROD_W-1:0] prod;
    logic [PROB_W-1:0]        prob_v;

    always_comb begin
        wd        = r_work[r_d];
        wr        = r_work[r_r];
        shortfall = (WORK_W+1)'(share_s) - (WORK_W+1)'(wr);
        diff      = DIFF_W'(wd) - DIFF_W'(shortfall);
        if (diff > D_MAX) begin
            donor_new = D_MAX[WORK_W-1:0];
        end else if (diff < D_MIN) begin
            donor_new = D_MIN[WORK_W-1:0];
        end else begin
            donor_new = diff[WORK_W-1:0];
        end
        prod = $signed({1'b0, n_use}) * wr;
        if (prod < 0) begin
            prob_v = '0;
        end else if (prod > P_MAX) begin
            prob_v = '1;
        end else begin
            prob_v = prod[PROB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work[slot] <= $signed(WORK_W'(i_pdf_value));
        end else if (i_cmd.update) begin
            // recipient zero wins when donor is the same column
            if (r_d != r_r) begin
                r_work[r_d] <= donor_new;
            end
            r_work[r_r] <= '0;
        end
    end

    // assigned marks
    logic [MAX_COLUMNS-1:0] r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.row_clr) begin
            r_mark <= '0;
        end else if (i_cmd.update) begin
            r_mark[r_r] <= 1'b1;
        end
    end

    // alias and probability table
    logic [ENT_W-1:0] table_mem [MAX_COLUMNS];
    logic [ENT_W-1:0] r_rd_data;
    logic             r_rd_mark;
    logic [IDX_W-1:0] step_idx;

    assign step_idx = r_step[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            table_mem[r_r] <= {r_d, prob_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= table_mem[step_idx];
            r_rd_mark <= r_mark[step_idx];
        end
    end

    // output register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [COL_W-1:0]  r_out_alias;
    logic [PROB_W-1:0] r_out_prob;
    logic              r_out_assigned;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_col      <= COL_W'(r_step);
            r_out_alias    <= r_rd_mark ? COL_W'(r_rd_data[ENT_W-1:PROB_W]) : '0;
            r_out_prob     <= r_rd_mark ? r_rd_data[PROB_W-1:0] : '0;
            r_out_assigned <= r_rd_mark;
            r_out_last     <= o_status.step_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_index  = r_out_col;
    assign o_alias_index   = r_out_alias;
    assign o_nonalias_prob = r_out_prob;
    assign o_assigned      = r_out_assigned;
    assign o_last_of_row   = r_out_last;

    assign o_status.load_last = (slot_ext + CNT_W'(1)) >= n_use;
    assign o_status.step_last = (r_step == (n_use - CNT_W'(1)));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ----- sv/alias_table_builder.sv -----
// Alias table row builder: n columns are loaded one per cycle, then n passes
// (each a search state, then an update state), then n results (each a table
// read, then an output write that waits until the output register is free).
// Synchronous active-low reset clears control state, marks and load count,
// and restores the column count and equal share defaults; no clearing pass.
module alias_table_builder #(
    parameter int MAX_COLUMNS = atb_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [atb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [atb_pkg::PDF_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [atb_pkg::PDF_W-1:0]        i_pdf_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [atb_pkg::COL_W-1:0]        o_column_index,
    output logic [atb_pkg::COL_W-1:0]        o_alias_index,
    output logic [atb_pkg::PROB_W-1:0]       o_nonalias_prob,
    output logic                             o_assigned,
    output logic                             o_last_of_row
);
    import atb_pkg::*;
    `include "alias_table_builder_macros.svh"

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    atb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    atb_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pdf_value     (i_pdf_value),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_column_index  (o_column_index),
        .o_alias_index   (o_alias_index),
        .o_nonalias_prob (o_nonalias_prob),
        .o_assigned      (o_assigned),
        .o_last_of_row   (o_last_of_row)
    );

    `ATB_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !o_out_valid || !i_out_stall, "result overwritten before transfer")
    `ATB_ASSERT_SAME(a_unassigned_zero, i_clk, i_rst_n, o_out_valid && !o_assigned, o_alias_index == '0 && o_nonalias_prob == '0, "unassigned entry carries data")
    `ATB_ASSERT_NEXT(a_stall_after_row, i_clk, i_rst_n, i_in_valid && !o_in_stall && status.load_last, o_in_stall, "input taken while row is built")

endmodule

// ----- test/tb_alias_table_builder.sv -----
// Self-checking testbench for the alias table row builder: loads rows of
// probability values, predicts every table entry and checks each result.
// Depends on atb_pkg and the alias_table_builder top level only.
`timescale 1ns / 100ps

module tb_alias_table_builder;
    import atb_pkg::*;

    localparam int MAXC   = MAX_COLUMNS_DEF;
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int SETTLE = 24;
    localparam int TAIL   = 100;
    localparam int LIMIT  = 400000;
    localparam int ITEMS  = 150;
    localparam longint WORK_MAX = (64'sd1 <<< (WORK_W - 1)) - 1;
    localparam longint WORK_MIN = -(64'sd1 <<< (WORK_W - 1));
    localparam longint PROB_MAX = (64'sd1 <<< PROB_W) - 1;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  alias_col;
        logic [PROB_W-1:0] prob;
        logic              assigned;
        logic              last_col;
    } t_table_entry;

    class alias_row_checker;
        longint             work[MAXC];
        logic [COL_W-1:0]   alias_tab[MAXC];
        logic [PROB_W-1:0]  prob_tab[MAXC];
        bit                 marks[MAXC];
        int                 load_cnt;
        logic [CNT_W-1:0]   col_cnt;
        logic [PDF_W-1:0]   share;
        t_table_entry       pending_entries[$];
        int                 errors;

        function new();
            foreach (work[i]) begin
                work[i]      = 0;
                alias_tab[i] = '0;
                prob_tab[i]  = '0;
                marks[i]     = 0;
            end
            load_cnt = 0;
            col_cnt  = COLS_RST;
            share    = SHARE_RST;
            errors   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [PDF_W-1:0] data);
            if (idx == CFG_COLUMN_COUNT) begin
                col_cnt = data[CNT_W-1:0];
            end else begin
                share = data;
            end
        endfunction

        function int cols_used();
            int n;
            n = col_cnt;
            if (n < 2) n = 2;
            if (n > MAXC) n = MAXC;
            return n;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Note one accepted pdf transfer; a completed row queues its entries.
        function void take_pdf(logic [PDF_W-1:0] v);
            int n, slot, d, r;
            longint s;
            t_table_entry e;
            n    = cols_used();
            slot = load_cnt;
            if (slot >= MAXC) slot = MAXC - 1;
            work[slot] = v;
            if (slot + 1 < n) begin
                load_cnt = slot + 1;
                return;
            end
            s = share;
            for (int pass = 0; pass < n; pass++) begin
                d = -1;
                r = -1;
                for (int j = 0; j < n; j++) begin
                    if (d < 0 && work[j] >= s) d = j;
                    if (r < 0 && work[j] > 0 && work[j] < s) r = j;
                end
                if (d < 0) d = 0;
                if (r < 0) r = 0;
                alias_tab[r] = COL_W'(d);
                prob_tab[r]  = PROB_W'(clamp(n * work[r], 0, PROB_MAX));
                marks[r]     = 1;
                // donor update first, so a donor that is also the recipient ends at zero
                work[d] = clamp(work[d] - (s - work[r]), WORK_MIN, WORK_MAX);
                work[r] = 0;
            end
            for (int c = 0; c < n; c++) begin
                e.column    = COL_W'(c);
                e.alias_col = marks[c] ? alias_tab[c] : '0;
                e.prob      = marks[c] ? prob_tab[c] : '0;
                e.assigned  = marks[c];
                e.last_col  = (c == n - 1);
                pending_entries.push_back(e);
                marks[c] = 0;
            end
            load_cnt = 0;
        endfunction

        function void field_err(string name, longint exp_v, longint act_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        endfunction

        function void check_entry(t_table_entry got);
            t_table_entry exp_e;
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry, actual column %0d", $time, got.column);
                errors++;
                return;
            end
            exp_e = pending_entries.pop_front();
            if (got.column !== exp_e.column)
                field_err("column_index", exp_e.column, got.column);
            if (got.alias_col !== exp_e.alias_col)
                field_err("alias_index", exp_e.alias_col, got.alias_col);
            if (got.prob !== exp_e.prob)
                field_err("nonalias_prob", exp_e.prob, got.prob);
            if (got.assigned !== exp_e.assigned)
                field_err("assigned", exp_e.assigned, got.assigned);
            if (got.last_col !== exp_e.last_col)
                field_err("last_of_row", exp_e.last_col, got.last_col);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [PDF_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PDF_W-1:0]      i_pdf_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COL_W-1:0]      o_column_index;
    logic [COL_W-1:0]      o_alias_index;
    logic [PROB_W-1:0]     o_nonalias_prob;
    logic                  o_assigned;
    logic                  o_last_of_row;

    alias_row_checker sb = new();
    bit               calm = 0;
    int               sent = 0;
    int               cycles = 0;
    logic [PDF_W-1:0] cur_share = SHARE_RST;

    alias_table_builder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pdf_value    (i_pdf_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_column_index (o_column_index),
        .o_alias_index  (o_alias_index),
        .o_nonalias_prob(o_nonalias_prob),
        .o_assigned     (o_assigned),
        .o_last_of_row  (o_last_of_row)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_entry({o_column_index, o_alias_index, o_nonalias_prob,
                            o_assigned, o_last_of_row});
    end

    // Enter at a falling edge, leave at the falling edge after the transfer.
    task automatic send_pdf(logic [PDF_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pdf_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_pdf(v);
        sent++;
        @(negedge i_clk);
    endtask

    // Wait out every pending entry, then let the block settle.
    task automatic wait_table_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_row(int cnt, logic [PDF_W-1:0] shr);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_data  <= PDF_W'(cnt);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_COLUMN_COUNT, PDF_W'(cnt));
        @(negedge i_clk);
        i_cfg_index <= CFG_EQUAL_SHARE;
        i_cfg_data  <= shr;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_EQUAL_SHARE, shr);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_share = shr;
    endtask

    function automatic logic [PDF_W-1:0] pick_pdf();
        int hi;
        hi = 2 * int'(cur_share) + 1;
        if (hi > ONE) hi = ONE;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PDF_W'(ONE);
            2: return (cur_share > ONE) ? PDF_W'(ONE) : cur_share;
            3: return (cur_share > 0) ? PDF_W'(cur_share - 1) : '0;
            4: return PDF_W'(1);
            default: return PDF_W'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) send_pdf(pick_pdf());
    endtask

    initial begin
        int row, cnt, eff, k, rnd;
        logic [PDF_W-1:0] shr;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no recipient at all, share at its top
        program_row(2, PDF_W'(ONE));
        send_pdf('0);
        send_pdf(PDF_W'(ONE));
        wait_table_idle();
        program_row(3, PDF_W'(ONE / 2));
        send_pdf(PDF_W'(ONE));
        send_pdf('0);
        send_pdf(PDF_W'(ONE / 2 - 1));
        wait_table_idle();
        // count below range, zero share: every value is a donor
        program_row(1, '0);
        send_pdf(PDF_W'(5));
        send_pdf(PDF_W'(ONE));
        wait_table_idle();
        program_row(4, PDF_W'(ONE / 3));
        send_pdf(PDF_W'(ONE / 4));
        send_pdf(PDF_W'(ONE / 2));
        send_pdf(PDF_W'(1));
        send_pdf(PDF_W'(ONE / 4 - 1));
        // shrink the count in the middle of a row
        wait_table_idle();
        program_row(8, PDF_W'(ONE / 7));
        send_pdf(PDF_W'(ONE / 3));
        send_pdf(PDF_W'(ONE / 9));
        send_pdf(PDF_W'(ONE - 1));
        wait_table_idle();
        program_row(2, PDF_W'(ONE / 7));
        send_pdf(PDF_W'(ONE / 5));
        wait_table_idle();
        program_row(5, PDF_W'(ONE / 4));
        send_random(5);

        row = 0;
        while (sent < ITEMS) begin
            rnd = $urandom_range(0, 99);
            if (row == 2) cnt = 64;
            else if (row == 5) cnt = 0;
            else if (rnd < 70) cnt = $urandom_range(2, 8);
            else if (rnd < 92) cnt = $urandom_range(9, 20);
            else if (rnd < 96) cnt = 127;
            else cnt = 1;
            eff = (cnt < 2) ? 2 : ((cnt > MAXC) ? MAXC : cnt);
            if ($urandom_range(0, 4) == 0) shr = PDF_W'($urandom_range(0, ONE));
            else shr = PDF_W'(ONE / (eff - 1));
            calm = (sent >= 70 && sent < 110);
            wait_table_idle();
            program_row(cnt, shr);
            if (eff > 2 && $urandom_range(0, 9) == 0) begin
                k = $urandom_range(1, eff - 1);
                send_random(k);
                wait_table_idle();
                program_row($urandom_range(2, 8), shr);
                eff = sb.cols_used();
                send_random((k >= eff) ? 1 : eff - k);
            end else begin
                send_random(eff);
            end
            row++;
        end
        calm = 0;

        wait_table_idle();
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_entries.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
